>>> rtl/dag_pkg.sv
// dag_pkg: shared types and constants for the distance attenuation gain core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps
package dag_pkg;
   localparam int DIST_W     = 24;             // input distance, signed Q16.8
   localparam int CFG_DIST_W = 23;             // near / far registers
   localparam int GAIN_FRAC  = 15;             // Q1.15 fraction bits
   localparam int GAIN_W     = 16;
   localparam int Q_W        = GAIN_FRAC;      // quotient bits, one per cell
   localparam int REM_W      = 24;             // remainder / divisor width
   localparam int NUM_CELLS  = Q_W;
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;
   localparam int PROD_W     = 34;             // signed 17 x 17 product

   typedef enum logic [1:0] {
      MODEL_LINEAR  = 2'd0,
      MODEL_LOG     = 2'd1,
      MODEL_INV_SQ  = 2'd2,
      MODEL_CUSTOM  = 2'd3
   } model_type;

   typedef enum logic [1:0] {
      CSR_NEAR  = 2'd0,
      CSR_FAR   = 2'd1,
      CSR_FLOOR = 2'd2,
      CSR_MODEL = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_FULL  = 2'd0,
      SEL_FLOOR = 2'd1,
      SEL_BLEND = 2'd2
   } sel_type;

   // Data handed from cell to cell: two restoring divisions side by side.
   typedef struct packed {
      logic             valid;
      sel_type          sel;
      logic [REM_W-1:0] t_rem;
      logic [REM_W-1:0] t_div;
      logic [Q_W-1:0]   t_q;
      logic [REM_W-1:0] r_rem;
      logic [REM_W-1:0] r_div;
      logic [Q_W-1:0]   r_q;
   } cell_type;

   typedef struct packed {
      logic [CFG_DIST_W-1:0] near_dist;
      logic [CFG_DIST_W-1:0] far_dist;
      logic [GAIN_W-1:0]     vol_floor;
      model_type             model;
   } cfg_type;
endpackage

>>> rtl/distance_attenuation_gain_core.sv
// distance_attenuation_gain_core: top level, distance in, Q1.15 gain out.
// Depends on dag_pkg, dag_front, dag_cell, dag_back.
`timescale 1ns / 1ps
// One distance transfer in, one gain transfer out, in order, one item per
// clock sustained while rsp_ready stays high. The pipe is 19 registers deep.
// The stages are one front stage, a row of 15 division cells (each cell
// resolves one quotient bit of both t = (d-near)/(far-near) and r = near/d),
// and three back stages (square, blend multiply, round/clamp into the output
// register). The whole row moves together; it holds only while a finished
// gain waits at rsp, so req_ready = !rsp_valid || rsp_ready. Registers are
// written through the csr port and must only be changed while the core is
// idle.
module distance_attenuation_gain_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [dag_pkg::DIST_W-1:0]   req_distance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dag_pkg::GAIN_W-1:0]          rsp_gain,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [dag_pkg::CFG_DIST_W-1:0]      csr_wdata
);
   import dag_pkg::*;

   cfg_type  cfg_ff;
   logic     adv;
   cell_type chain [NUM_CELLS+1];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.near_dist <= CFG_DIST_W'(256);
         cfg_ff.far_dist  <= CFG_DIST_W'(25600);
         cfg_ff.vol_floor <= '0;
         cfg_ff.model     <= MODEL_LINEAR;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_NEAR:  cfg_ff.near_dist <= csr_wdata;
            CSR_FAR:   cfg_ff.far_dist  <= csr_wdata;
            CSR_FLOOR: cfg_ff.vol_floor <= csr_wdata[GAIN_W-1:0];
            CSR_MODEL: cfg_ff.model     <= model_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   // the whole pipeline advances unless a result is stuck at the output
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   dag_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .distance (req_distance),
      .cfg      (cfg_ff),
      .cell_out (chain[0])
   );

   // row of division cells, one quotient bit each
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      dag_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .cell_in_d (chain[i]),
         .cell_out  (chain[i+1])
      );
   end

   dag_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cell_in_d (chain[NUM_CELLS]),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .gain      (rsp_gain)
   );
endmodule

>>> rtl/dag_front.sv
// dag_front: clamps the distance, classifies it and seeds both divisions.
// Depends on dag_pkg.
`timescale 1ns / 1ps
module dag_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic signed [dag_pkg::DIST_W-1:0] distance,
   input  dag_pkg::cfg_type             cfg,
   output dag_pkg::cell_type            cell_out
);
   import dag_pkg::*;

   cell_type          cell_ff, cell_in;
   logic [REM_W-1:0]  d, nearv, farv;

   always_comb begin
      d     = distance[DIST_W-1] ? '0 : REM_W'(distance[DIST_W-2:0]);
      nearv = REM_W'(cfg.near_dist);
      farv  = (cfg.far_dist > cfg.near_dist) ? REM_W'(cfg.far_dist) : nearv + 1'b1;
      cell_in.valid = in_valid;
      if (d <= nearv) begin
         cell_in.sel = SEL_FULL;
      end else if (d >= farv) begin
         cell_in.sel = SEL_FLOOR;
      end else begin
         cell_in.sel = SEL_BLEND;
      end
      cell_in.t_rem = d - nearv;
      cell_in.t_div = farv - nearv;
      cell_in.t_q   = '0;
      cell_in.r_rem = nearv;
      cell_in.r_div = d;
      cell_in.r_q   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;
endmodule

>>> rtl/dag_cell.sv
// dag_cell: one quotient bit of both restoring divisions per cell.
// Depends on dag_pkg.
`timescale 1ns / 1ps
module dag_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  dag_pkg::cell_type cell_in_d,
   output dag_pkg::cell_type cell_out
);
   import dag_pkg::*;

   cell_type         cell_ff, cell_in;
   logic [REM_W-1:0] t_sh, r_sh;

   always_comb begin
      cell_in = cell_in_d;
      t_sh = {cell_in_d.t_rem[REM_W-2:0], 1'b0};
      r_sh = {cell_in_d.r_rem[REM_W-2:0], 1'b0};
      if (t_sh >= cell_in_d.t_div) begin
         cell_in.t_rem = t_sh - cell_in_d.t_div;
         cell_in.t_q   = {cell_in_d.t_q[Q_W-2:0], 1'b1};
      end else begin
         cell_in.t_rem = t_sh;
         cell_in.t_q   = {cell_in_d.t_q[Q_W-2:0], 1'b0};
      end
      if (r_sh >= cell_in_d.r_div) begin
         cell_in.r_rem = r_sh - cell_in_d.r_div;
         cell_in.r_q   = {cell_in_d.r_q[Q_W-2:0], 1'b1};
      end else begin
         cell_in.r_rem = r_sh;
         cell_in.r_q   = {cell_in_d.r_q[Q_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;
endmodule

>>> rtl/dag_back.sv
// dag_back: shape select, blend toward the floor, clamp and output register.
// Depends on dag_pkg.
`timescale 1ns / 1ps
module dag_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  dag_pkg::cell_type          cell_in_d,
   input  dag_pkg::cfg_type           cfg,
   output logic                       out_valid,
   output logic [dag_pkg::GAIN_W-1:0] gain
);
   import dag_pkg::*;

   // stage 1: 1 - t and r squared
   logic                   s1_valid_ff;
   sel_type                s1_sel_ff;
   logic [GAIN_W-1:0]      s1_omt_ff, s1_omt_in;
   logic [Q_W-1:0]         s1_r_ff;
   logic [2*Q_W-1:0]       s1_rsq_ff, s1_rsq_in;
   // stage 2: (shape - floor) * (1 - t)
   logic                   s2_valid_ff;
   sel_type                s2_sel_ff;
   logic signed [PROD_W-1:0] s2_prod_ff, s2_prod_in;
   logic [GAIN_W-1:0]      flo, shape;
   logic signed [GAIN_W:0] diff, omt_s;
   // stage 3: output
   logic                   out_valid_ff;
   logic [GAIN_W-1:0]      gain_ff, gain_in;
   logic signed [PROD_W-1:0] q;
   logic signed [PROD_W-1:0] blend;

   always_comb begin
      flo       = (cfg.vol_floor > GAIN_ONE) ? GAIN_ONE : cfg.vol_floor;
      s1_omt_in = GAIN_ONE - GAIN_W'(cell_in_d.t_q);
      s1_rsq_in = cell_in_d.r_q * cell_in_d.r_q;

      case (cfg.model)
         MODEL_LINEAR: shape = s1_omt_ff;
         MODEL_INV_SQ: shape = GAIN_W'(s1_rsq_ff >> GAIN_FRAC);
         default:      shape = GAIN_W'(s1_r_ff);
      endcase
      diff       = $signed({1'b0, shape}) - $signed({1'b0, flo});
      omt_s      = $signed({1'b0, s1_omt_ff});
      s2_prod_in = PROD_W'(diff) * PROD_W'(omt_s);

      // divide by unity, truncating toward zero
      q = $signed(s2_prod_ff + (s2_prod_ff[PROD_W-1] ? PROD_W'(GAIN_ONE - 1'b1) : '0))
          >>> GAIN_FRAC;
      blend = $signed(PROD_W'(flo)) + q;
      case (s2_sel_ff)
         SEL_FULL:  gain_in = GAIN_ONE;
         SEL_FLOOR: gain_in = flo;
         default: begin
            if (blend < $signed(PROD_W'(flo))) begin
               gain_in = flo;
            end else if (blend > $signed(PROD_W'(GAIN_ONE))) begin
               gain_in = GAIN_ONE;
            end else begin
               gain_in = blend[GAIN_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= cell_in_d.valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sel_ff  <= cell_in_d.sel;
         s1_omt_ff  <= s1_omt_in;
         s1_r_ff    <= cell_in_d.r_q;
         s1_rsq_ff  <= s1_rsq_in;
         s2_sel_ff  <= s1_sel_ff;
         s2_prod_ff <= s2_prod_in;
         gain_ff    <= gain_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign gain      = gain_ff;
endmodule
